### rtl/core/assert_macros.svh
// assertion helpers shared by the core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

### rtl/core/mmcp_pkg.sv
package mmcp_pkg;

    localparam int MAX_BOOKS_DEF = 1024;
    localparam int PAGE_BITS_DEF = 16;

    localparam int STUDENT_W = 11;
    localparam logic [STUDENT_W-1:0] STUDENT_RST = 11'd1;

    typedef struct packed {
        logic load;
        logic search_init;
        logic trial_init;
        logic trial_run;
        logic decide;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic search_done;
        logic trial_done;
    } t_dp_stat;

endpackage

### rtl/core/min_max_contiguous_partition_top.sv
// load: one beat per cycle while busy is low; the beat with i_last_book set starts the search
// search: at most floor(log2(total - min + 1)) + 1 trials, each a greedy pass over at most
// the N books held, one book per cycle from the single read port of the store
// result: o_strobe high for one cycle, from ST_SETUP after the last trial; busy drops with it
// the receiver cannot stall; a new set may load from the strobe cycle on
// reset (synchronous, active low): set cleared, student count back to 1, store left as is
module min_max_contiguous_partition_top #(
    parameter int MAX_BOOKS = mmcp_pkg::MAX_BOOKS_DEF,
    parameter int PAGE_BITS = mmcp_pkg::PAGE_BITS_DEF,
    localparam int TOT_W    = PAGE_BITS + $clog2(MAX_BOOKS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [PAGE_BITS-1:0]           i_page_count,
    input  logic                           i_last_book,
    input  logic                           i_cfg_wr_en,
    input  logic [mmcp_pkg::STUDENT_W-1:0] i_cfg_wr_data,
    output logic                           o_strobe,
    output logic [TOT_W-1:0]               o_min_max_pages
);

    mmcp_pkg::t_dp_cmd  dp_cmd;
    mmcp_pkg::t_dp_stat dp_stat;

    mmcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_last_book (i_last_book),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd),
        .busy        (busy),
        .o_strobe    (o_strobe)
    );

    mmcp_datapath #(
        .MAX_BOOKS (MAX_BOOKS),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_page_count    (i_page_count),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_min_max_pages (o_min_max_pages)
    );

endmodule

### rtl/core/mmcp_ctrl.sv
module mmcp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               i_last_book,
    input  mmcp_pkg::t_dp_stat i_stat,
    output mmcp_pkg::t_dp_cmd  o_cmd,
    output logic               busy,
    output logic               o_strobe
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_SETUP,
        ST_TRIAL,
        ST_DECIDE
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    always_comb begin
        o_cmd             = '0;
        o_cmd.load        = (r_state == ST_LOAD) && start && !r_busy;
        o_cmd.search_init = (r_state == ST_INIT);
        o_cmd.trial_init  = (r_state == ST_SETUP) && !i_stat.search_done;
        o_cmd.clear       = (r_state == ST_SETUP) && i_stat.search_done;
        o_cmd.trial_run   = (r_state == ST_TRIAL);
        o_cmd.decide      = (r_state == ST_DECIDE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_LOAD: begin
                    if (start && !r_busy && i_last_book) begin
                        r_state <= ST_INIT;
                        r_busy  <= 1'b1;
                    end
                end
                ST_INIT: begin
                    r_state <= ST_SETUP;
                end
                ST_SETUP: begin
                    if (i_stat.search_done) begin
                        r_state  <= ST_LOAD;
                        r_busy   <= 1'b0;
                        r_strobe <= 1'b1;
                    end else begin
                        r_state <= ST_TRIAL;
                    end
                end
                ST_TRIAL: begin
                    if (i_stat.trial_done) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_state <= ST_SETUP;
                end
                default: begin
                    r_state <= ST_LOAD;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

    `ASSERT_CLK(a_strobe_single, i_clk, i_rst_n, r_strobe |=> !r_strobe, "strobe held over two cycles")
    `ASSERT_CLK(a_strobe_ends_search, i_clk, i_rst_n, r_strobe |-> !r_busy && $past(r_busy), "result without a search")
    `ASSERT_NEVER(a_idle_not_busy, i_clk, i_rst_n, !r_busy && r_state != ST_LOAD, "search state while not busy")

endmodule

### rtl/core/mmcp_datapath.sv
module mmcp_datapath #(
    parameter int MAX_BOOKS = mmcp_pkg::MAX_BOOKS_DEF,
    parameter int PAGE_BITS = mmcp_pkg::PAGE_BITS_DEF,
    localparam int AW    = (MAX_BOOKS > 1) ? $clog2(MAX_BOOKS) : 1,
    localparam int CW    = $clog2(MAX_BOOKS + 1),
    localparam int TOT_W = PAGE_BITS + $clog2(MAX_BOOKS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mmcp_pkg::t_dp_cmd              i_cmd,
    output mmcp_pkg::t_dp_stat             o_stat,
    input  logic [PAGE_BITS-1:0]           i_page_count,
    input  logic                           i_cfg_wr_en,
    input  logic [mmcp_pkg::STUDENT_W-1:0] i_cfg_wr_data,
    output logic [TOT_W-1:0]               o_min_max_pages
);

`include "assert_macros.svh"

    localparam int SW    = TOT_W + 1;
    localparam int CMP_W = (CW > mmcp_pkg::STUDENT_W) ? CW : mmcp_pkg::STUDENT_W;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BOOKS);

    logic [PAGE_BITS-1:0]           r_mem [MAX_BOOKS];
    logic [PAGE_BITS-1:0]           r_rd_data;
    logic [mmcp_pkg::STUDENT_W-1:0] r_student_count;
    logic [CW-1:0]                  r_count;
    logic [PAGE_BITS-1:0]           r_min;
    logic [TOT_W-1:0]               r_total;

    logic [SW-1:0]    r_low;
    logic [SW-1:0]    r_high;
    logic [SW-1:0]    r_mid;
    logic [TOT_W-1:0] r_answer;
    logic             r_stop;

    logic [CW-1:0] r_rd_idx;
    logic          r_rd_vld;
    logic [SW-1:0] r_seg;
    logic [CW-1:0] r_cuts;
    logic          r_fail;

    logic          mem_wr;
    logic          rd_issue;
    logic [SW:0]   mid_sum;
    logic [SW-1:0] book;
    logic [SW-1:0] seg_sum;
    logic          fits;

    assign mem_wr   = i_cmd.load && (r_count < COUNT_MAX);
    assign rd_issue = i_cmd.trial_run && (r_rd_idx != r_count) && !r_fail;
    assign mid_sum  = {1'b0, r_low} + {1'b0, r_high};
    assign book     = SW'(r_rd_data);
    assign seg_sum  = r_seg + book;
    assign fits     = !r_fail && (CMP_W'(r_cuts) < CMP_W'(r_student_count));

    // store and registered read port
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_count[AW-1:0]] <= i_page_count;
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

    // set statistics and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_student_count <= mmcp_pkg::STUDENT_RST;
            r_count         <= '0;
            r_min           <= '1;
            r_total         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_student_count <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_min   <= '1;
                r_total <= '0;
            end else if (mem_wr) begin
                r_count <= r_count + CW'(1);
                r_total <= r_total + TOT_W'(i_page_count);
                if (i_page_count < r_min) begin
                    r_min <= i_page_count;
                end
            end
        end
    end

    // search bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop <= 1'b0;
        end else if (i_cmd.search_init) begin
            r_stop <= 1'b0;
        end else if (i_cmd.decide && fits && r_mid == '0) begin
            r_stop <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search_init) begin
            r_low    <= SW'(r_min);
            r_high   <= SW'(r_total);
            r_answer <= '0;
        end else if (i_cmd.trial_init) begin
            r_mid <= mid_sum[SW:1];
        end else if (i_cmd.decide) begin
            if (fits) begin
                r_answer <= r_mid[TOT_W-1:0];
                if (r_mid != '0) begin
                    r_high <= r_mid - SW'(1);
                end
            end else begin
                r_low <= r_mid + SW'(1);
            end
        end
    end

    // greedy trial, one book per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
            r_fail   <= 1'b0;
        end else if (i_cmd.trial_init) begin
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
            r_fail   <= 1'b0;
        end else begin
            r_rd_vld <= rd_issue;
            if (rd_issue) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (r_rd_vld && !r_fail && seg_sum > r_mid && book > r_mid) begin
                r_fail <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.trial_init) begin
            r_seg  <= '0;
            r_cuts <= '0;
        end else if (r_rd_vld && !r_fail) begin
            if (seg_sum > r_mid) begin
                r_cuts <= r_cuts + CW'(1);
                r_seg  <= book;
            end else begin
                r_seg <= seg_sum;
            end
        end
    end

    assign o_stat.search_done = r_stop || (r_low > r_high);
    assign o_stat.trial_done  = (r_fail || r_rd_idx == r_count) && !r_rd_vld;
    assign o_min_max_pages    = r_answer;

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > COUNT_MAX, "book count past store depth")
    `ASSERT_CLK(a_mid_in_range, i_clk, i_rst_n, i_cmd.trial_run |-> (r_mid >= r_low && r_mid <= r_high), "trial limit outside bounds")
    `ASSERT_NEVER(a_read_in_set, i_clk, i_rst_n, rd_issue && r_rd_idx >= r_count, "read beyond loaded books")

endmodule
